>>> rtl/wsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the waveform sample generator
// Period length, reciprocal constants for the constant divisions, sine
// polynomial coefficients, register codes and the words passed between units.
// ----------------------------------------------------------------------------
package wsg_pkg;

	// period length in points
	localparam int SAMPLES = 400;

	// fixed field widths
	localparam int TYPE_W   = 3;
	localparam int AMP_W    = 8;
	localparam int PHASE_W  = 16;
	localparam int SAMPLE_W = 8;
	localparam int PIDX_W   = 9;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_WAVE_TYPE = 2'd0;
	localparam logic [CIDX_W-1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [CIDX_W-1:0] REG_PHASE     = 2'd2;

	// register reset values
	localparam logic [TYPE_W-1:0]  RST_WAVE_TYPE = 3'd1;
	localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 8'd77;
	localparam logic [PHASE_W-1:0] RST_PHASE     = 16'd0;

	// wave type codes
	localparam logic [TYPE_W-1:0] WAVE_SINE   = 3'd0;
	localparam logic [TYPE_W-1:0] WAVE_SQUARE = 3'd1;
	localparam logic [TYPE_W-1:0] WAVE_SAW    = 3'd2;
	localparam logic [TYPE_W-1:0] WAVE_TRI    = 3'd3;

	// point counter and ramp operand
	localparam int IW = $clog2(SAMPLES);
	localparam int UW = $clog2(SAMPLES + 2);

	// angle numerator modulo DEN, turn fraction t = num * 2^32 / DEN
	// split as num * RECIP_Q + floor(num * RECIP_R / DEN)
	localparam longint unsigned DEN     = 360 * SAMPLES;
	localparam int              DW      = $clog2(DEN);
	localparam longint unsigned TURN    = 64'd1 << 32;
	localparam longint unsigned RECIP_Q = TURN / DEN;
	localparam longint unsigned RECIP_R = TURN % DEN;
	localparam int              XW      = 2 * DW;
	localparam longint unsigned RECIP_M = (64'd1 << XW) / DEN;
	localparam int              MW      = $clog2(RECIP_M + 1);

	// ramp divide by SAMPLES
	localparam int              YW    = $clog2(255 * (SAMPLES + 1) + 1);
	localparam longint unsigned DIV_M = (64'd1 << YW) / SAMPLES;
	localparam int              DMW   = $clog2(DIV_M + 1);
	localparam int              RW    = 9;

	// degree offset: floor(phase / 2) mod 360
	localparam int DEG_SHIFT = PHASE_W - 1;
	localparam int DEG_MUL   = (1 << DEG_SHIFT) / 360;
	localparam int DEG_QW    = $clog2(((1 << DEG_SHIFT) - 1) / 360 + 1);
	localparam int DEG_W     = 9;

	// sine polynomial in Q30
	localparam logic [31:0] C1  = 32'd1686629713;
	localparam logic [31:0] C3  = 32'd693598668;
	localparam logic [31:0] C5  = 32'd85569305;
	localparam logic [31:0] C7  = 32'd5026995;
	localparam logic [31:0] C9  = 32'd172272;
	localparam logic [30:0] Q30 = 31'h4000_0000;

	// receive queue
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// back end pipeline length, output register included
	localparam int NST = 17;

	typedef logic [IW-1:0]        idx_t;
	typedef logic [UW-1:0]        u_t;
	typedef logic [DW-1:0]        num_t;
	typedef logic [DW:0]          nsum_t;
	typedef logic [XW-1:0]        xr_t;
	typedef logic [XW+MW-1:0]     xm_t;
	typedef logic [31:0]          turn_t;
	typedef logic [YW-1:0]        y_t;
	typedef logic [YW+DMW-1:0]    ym_t;
	typedef logic [RW-1:0]        ratio_t;
	typedef logic [30:0]          x_t;
	typedef logic [31:0]          coef_t;
	typedef logic [16:0]          v_t;
	typedef logic [24:0]          va_t;
	typedef logic [DEG_W-1:0]     deg_t;
	typedef logic [DEG_QW-1:0]    degq_t;
	typedef logic [PIDX_W-1:0]    pidx_t;
	typedef logic [QPW-1:0]       qptr_t;
	typedef logic [QCW-1:0]       qcnt_t;

	typedef enum logic [2:0] {
		KIND_SINE_OFS   = 3'd0,
		KIND_SQUARE     = 3'd1,
		KIND_SAW        = 3'd2,
		KIND_TRI        = 3'd3,
		KIND_SINE_PLAIN = 3'd4
	} kind_t;

	// classified point, front end to back end
	typedef struct packed {
		idx_t  idx;
		logic  pend;
		logic  half;
		kind_t kind;
		u_t    u;
	} item_t;

	// word riding along the back end pipeline
	typedef struct packed {
		idx_t   idx;
		logic   pend;
		logic   half;
		kind_t  kind;
		ratio_t ratio;
	} side_t;

	// one Horner step: c - (x2 * p) >> 30
	function automatic coef_t horner(x_t x2, coef_t p, coef_t c);
		logic [62:0] m;
		m = {32'b0, x2} * {31'b0, p};
		return c - coef_t'(m >> 30);
	endfunction

endpackage
`default_nettype wire

>>> rtl/wsg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_front: point counter and classifier
// Takes input words, steps the point counter and hands one classified point
// per accepted word to the receive queue.
// ----------------------------------------------------------------------------
module wsg_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         restart,
	input  wire logic [wsg_pkg::TYPE_W-1:0]   wave_type,
	input  wire logic                         q_full,
	output logic                              in_stall,
	output logic                              push,
	output wsg_pkg::item_t                    item
);

	wsg_pkg::idx_t counter_q;
	wsg_pkg::idx_t cur;
	logic          last;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// pick the point for this word
	always_comb begin
		if (restart || counter_q >= wsg_pkg::SAMPLES) begin
			cur = '0;
		end else begin
			cur = counter_q;
		end
		last = (int'(cur) == wsg_pkg::SAMPLES - 1);
	end

	// classify the point
	always_comb begin
		item.idx  = cur;
		item.pend = last;
		item.half = (int'(cur) < wsg_pkg::SAMPLES / 2);
		item.u    = '0;
		case (wave_type)
			wsg_pkg::WAVE_SINE: begin
				item.kind = wsg_pkg::KIND_SINE_OFS;
			end
			wsg_pkg::WAVE_SQUARE: begin
				item.kind = wsg_pkg::KIND_SQUARE;
			end
			wsg_pkg::WAVE_SAW: begin
				item.kind = wsg_pkg::KIND_SAW;
				item.u    = wsg_pkg::u_t'(cur);
			end
			wsg_pkg::WAVE_TRI: begin
				item.kind = wsg_pkg::KIND_TRI;
				if (item.half) begin
					item.u = wsg_pkg::u_t'(int'(cur) * 2);
				end else begin
					item.u = wsg_pkg::u_t'((wsg_pkg::SAMPLES - int'(cur)) * 2);
				end
			end
			default: begin
				item.kind = wsg_pkg::KIND_SINE_PLAIN;
			end
		endcase
	end

	// advance the counter, wrap at the period end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (push) begin
			if (last) begin
				counter_q <= '0;
			end else begin
				counter_q <= cur + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/wsg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_queue: receive queue between front end and back end
// Short register queue so that the counter side and the arithmetic side
// stall independently.
// ----------------------------------------------------------------------------
module wsg_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire wsg_pkg::item_t      wr_item,
	input  wire logic                pop,
	output wsg_pkg::item_t           head,
	output logic                     empty,
	output logic                     full
);

	wsg_pkg::item_t mem_q [wsg_pkg::QDEPTH];
	wsg_pkg::qptr_t wptr_q;
	wsg_pkg::qptr_t rptr_q;
	wsg_pkg::qcnt_t count_q;

	assign empty = (count_q == '0);
	assign full  = (int'(count_q) == wsg_pkg::QDEPTH);
	assign head  = mem_q[rptr_q];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				if (int'(wptr_q) == wsg_pkg::QDEPTH - 1) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (int'(rptr_q) == wsg_pkg::QDEPTH - 1) begin
					rptr_q <= '0;
				end else begin
					rptr_q <= rptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/wsg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_back: sample arithmetic pipeline
// Angle reduction, turn fraction, Q30 sine polynomial and ramp divide,
// ending in the output register.
// ----------------------------------------------------------------------------
module wsg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wsg_pkg::item_t                head,
	input  wire logic                          q_empty,
	output logic                               pop,
	input  wire logic [wsg_pkg::AMP_W-1:0]     amplitude,
	input  wire wsg_pkg::deg_t                 deg,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [wsg_pkg::SAMPLE_W-1:0]       sample,
	output logic [wsg_pkg::PIDX_W-1:0]         point_index,
	output logic                               period_end
);

	logic [wsg_pkg::NST:1] vld_q;
	logic                  adv;

	wsg_pkg::side_t  side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	wsg_pkg::side_t  side_s9, side_s10, side_s11, side_s12, side_s13, side_s14, side_s15;
	wsg_pkg::side_t  side_s16;
	wsg_pkg::side_t  side_c;
	wsg_pkg::side_t  side_r;
	wsg_pkg::y_t     y_s1, y_s2, y_s3;
	wsg_pkg::num_t   i360_s1, num_s2;
	wsg_pkg::ratio_t qy_s2, qy_s3;
	wsg_pkg::y_t     py_s3;
	wsg_pkg::xr_t    xr_s3, xr_s4, xr_s5;
	wsg_pkg::turn_t  nq_s3, nq_s4, nq_s5, nq_s6;
	wsg_pkg::num_t   qe_s4, qe_s5, q_s6;
	wsg_pkg::xr_t    pq_s5;
	wsg_pkg::turn_t  t_s7;
	logic [1:0]      quad_s8, quad_s9, quad_s10, quad_s11, quad_s12, quad_s13, quad_s14;
	wsg_pkg::x_t     x_s8, x_s9, x_s10, x_s11, x_s12, x_s13;
	wsg_pkg::x_t     x2_s9, x2_s10, x2_s11, x2_s12;
	wsg_pkg::coef_t  p_s10, p_s11, p_s12, p_s13;
	wsg_pkg::x_t     sn_s14;
	wsg_pkg::v_t     v_s15;
	wsg_pkg::va_t    va_s16;
	logic [wsg_pkg::SAMPLE_W-1:0] sample_s17;
	wsg_pkg::pidx_t  pidx_s17;
	logic            pend_s17;

	wsg_pkg::deg_t   deg_use;
	wsg_pkg::nsum_t  nsum;
	wsg_pkg::ym_t    ym;
	wsg_pkg::y_t     ry;
	wsg_pkg::ratio_t ratio_c;
	wsg_pkg::xm_t    xm;
	wsg_pkg::xr_t    rem;
	logic [61:0]     sq;
	logic [62:0]     sp;
	logic [61:0]     sp30;
	logic [31:0]     s16w;
	logic [17:0]     vw;
	logic [25:0]     va_rnd;
	logic [9:0]      res;

	// move everything when the output register is free or being taken
	assign adv = !vld_q[wsg_pkg::NST] || !out_stall;
	assign pop = adv && !q_empty;

	assign out_valid   = vld_q[wsg_pkg::NST];
	assign sample      = sample_s17;
	assign point_index = pidx_s17;
	assign period_end  = pend_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[wsg_pkg::NST-1:1], pop};
		end
	end

	// stage combinational terms
	always_comb begin
		side_c.idx   = head.idx;
		side_c.pend  = head.pend;
		side_c.half  = head.half;
		side_c.kind  = head.kind;
		side_c.ratio = '0;

		// degree offset only for the offset sine
		deg_use = (side_s1.kind == wsg_pkg::KIND_SINE_OFS) ? deg : '0;
		nsum    = wsg_pkg::nsum_t'(i360_s1)
			+ wsg_pkg::nsum_t'(int'(deg_use) * wsg_pkg::SAMPLES);

		// ramp quotient estimate and correction
		ym = wsg_pkg::ym_t'(y_s1) * wsg_pkg::ym_t'(wsg_pkg::DIV_M);
		ry = y_s3 - py_s3;
		if (ry >= wsg_pkg::SAMPLES) begin
			ratio_c = qy_s3 + 1'b1;
		end else begin
			ratio_c = qy_s3;
		end
		side_r       = side_s3;
		side_r.ratio = ratio_c;

		// turn fraction remainder estimate and correction
		xm  = wsg_pkg::xm_t'(xr_s3) * wsg_pkg::xm_t'(wsg_pkg::RECIP_M);
		rem = xr_s5 - pq_s5;

		sq   = {31'b0, x_s8} * {31'b0, x_s8};
		sp   = {32'b0, x_s13} * {31'b0, p_s13};
		sp30 = 62'(sp >> 30);

		s16w = (32'(sn_s14) + 32'd8192) >> 14;
		if (s16w > 32'd65536) begin
			s16w = 32'd65536;
		end
		if (quad_s14[1] == 1'b0) begin
			vw = 18'd65536 + 18'(s16w);
		end else begin
			vw = 18'd65536 - 18'(s16w);
		end
		if (vw > 18'd131071) begin
			vw = 18'd131071;
		end

		// pick the sample for the wave kind
		va_rnd = 26'(va_s16) + 26'd65536;
		case (side_s16.kind)
			wsg_pkg::KIND_SINE_OFS: res = 10'(va_rnd >> 17);
			wsg_pkg::KIND_SQUARE:   res = side_s16.half ? 10'(amplitude) : 10'd0;
			wsg_pkg::KIND_SAW:      res = 10'(side_s16.ratio);
			wsg_pkg::KIND_TRI:      res = 10'(side_s16.ratio);
			default:                res = 10'(va_s16 >> 17);
		endcase
		if (res > 10'd255) begin
			res = 10'd255;
		end
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: ramp product, angle base
			side_s1 <= side_c;
			y_s1    <= wsg_pkg::y_t'(head.u) * wsg_pkg::y_t'(amplitude);
			i360_s1 <= wsg_pkg::num_t'(int'(head.idx) * 360);

			// s2: add offset and wrap, ramp reciprocal
			side_s2 <= side_s1;
			if (nsum >= wsg_pkg::DEN) begin
				num_s2 <= wsg_pkg::num_t'(nsum - wsg_pkg::nsum_t'(wsg_pkg::DEN));
			end else begin
				num_s2 <= wsg_pkg::num_t'(nsum);
			end
			qy_s2 <= wsg_pkg::ratio_t'(ym >> wsg_pkg::YW);
			y_s2  <= y_s1;

			// s3: split the turn fraction, ramp back product
			side_s3 <= side_s2;
			xr_s3   <= wsg_pkg::xr_t'(num_s2) * wsg_pkg::xr_t'(wsg_pkg::RECIP_R);
			nq_s3   <= wsg_pkg::turn_t'(num_s2) * wsg_pkg::turn_t'(wsg_pkg::RECIP_Q);
			py_s3   <= wsg_pkg::y_t'(qy_s2) * wsg_pkg::y_t'(wsg_pkg::SAMPLES);
			qy_s3   <= qy_s2;
			y_s3    <= y_s2;

			// s4: remainder quotient estimate, ramp result
			side_s4 <= side_r;
			qe_s4   <= wsg_pkg::num_t'(xm >> wsg_pkg::XW);
			xr_s4   <= xr_s3;
			nq_s4   <= nq_s3;

			// s5: back product
			side_s5 <= side_s4;
			pq_s5   <= wsg_pkg::xr_t'(qe_s4) * wsg_pkg::xr_t'(wsg_pkg::DEN);
			qe_s5   <= qe_s4;
			xr_s5   <= xr_s4;
			nq_s5   <= nq_s4;

			// s6: correct the estimate
			side_s6 <= side_s5;
			q_s6    <= (rem >= wsg_pkg::DEN) ? qe_s5 + 1'b1 : qe_s5;
			nq_s6   <= nq_s5;

			// s7: turn fraction
			side_s7 <= side_s6;
			t_s7    <= nq_s6 + wsg_pkg::turn_t'(q_s6);

			// s8: quadrant and mirror
			side_s8 <= side_s7;
			quad_s8 <= t_s7[31:30];
			if (t_s7[30]) begin
				x_s8 <= wsg_pkg::Q30 - {1'b0, t_s7[29:0]};
			end else begin
				x_s8 <= {1'b0, t_s7[29:0]};
			end

			// s9: square
			side_s9 <= side_s8;
			quad_s9 <= quad_s8;
			x_s9    <= x_s8;
			x2_s9   <= wsg_pkg::x_t'(sq >> 30);

			// s10..s13: Horner steps
			side_s10 <= side_s9;
			quad_s10 <= quad_s9;
			x_s10    <= x_s9;
			x2_s10   <= x2_s9;
			p_s10    <= wsg_pkg::horner(x2_s9, wsg_pkg::C9, wsg_pkg::C7);

			side_s11 <= side_s10;
			quad_s11 <= quad_s10;
			x_s11    <= x_s10;
			x2_s11   <= x2_s10;
			p_s11    <= wsg_pkg::horner(x2_s10, p_s10, wsg_pkg::C5);

			side_s12 <= side_s11;
			quad_s12 <= quad_s11;
			x_s12    <= x_s11;
			x2_s12   <= x2_s11;
			p_s12    <= wsg_pkg::horner(x2_s11, p_s11, wsg_pkg::C3);

			side_s13 <= side_s12;
			quad_s13 <= quad_s12;
			x_s13    <= x_s12;
			p_s13    <= wsg_pkg::horner(x2_s12, p_s12, wsg_pkg::C1);

			// s14: sine, clamp to one
			side_s14 <= side_s13;
			quad_s14 <= quad_s13;
			if (sp30 > 62'(wsg_pkg::Q30)) begin
				sn_s14 <= wsg_pkg::Q30;
			end else begin
				sn_s14 <= wsg_pkg::x_t'(sp30);
			end

			// s15: offset sine in Q1.16
			side_s15 <= side_s14;
			v_s15    <= wsg_pkg::v_t'(vw);

			// s16: scale by amplitude
			side_s16 <= side_s15;
			va_s16   <= wsg_pkg::va_t'(v_s15) * wsg_pkg::va_t'(amplitude);

			// s17: output register
			sample_s17 <= res[wsg_pkg::SAMPLE_W-1:0];
			pidx_s17   <= wsg_pkg::pidx_t'(side_s16.idx);
			pend_s17   <= side_s16.pend;
		end
	end

endmodule
`default_nettype wire

>>> rtl/waveform_sample_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_sample_generator: function generator sample source
// Sine with offset, plain sine, square, sawtooth and triangle over a period
// of SAMPLES points, one unsigned DAC code per input word.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   restart
//   out       source     out_valid / out_stall sample, point_index, period_end
//   cfg       sink       cfg_wr_en             cfg_index, cfg_wdata
//
// One word per clock sustained while out_stall stays low; a taken word is
// written into the queue, then passes the seventeen back end stages, the
// output register last. Reset (arst_n low) restores wave_type 1, amplitude
// 77, phase 0, counter 0. out_stall with a word in the output register
// freezes the back end; the two-entry queue then fills and in_stall rises.
// A phase write passes phase_q and degq_q before it reaches the degree offset.
// ----------------------------------------------------------------------------
module waveform_sample_generator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            restart,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [wsg_pkg::SAMPLE_W-1:0]         sample,
	output logic [wsg_pkg::PIDX_W-1:0]           point_index,
	output logic                                 period_end,
	input  wire logic                            cfg_wr_en,
	input  wire logic [wsg_pkg::CIDX_W-1:0]      cfg_index,
	input  wire logic [wsg_pkg::CDATA_W-1:0]     cfg_wdata
);

	logic [wsg_pkg::TYPE_W-1:0]  wave_type_q;
	logic [wsg_pkg::AMP_W-1:0]   amp_q;
	logic [wsg_pkg::PHASE_W-1:0] phase_q;
	wsg_pkg::degq_t              degq_q;
	wsg_pkg::deg_t               deg_q;
	logic [15:0]                 deg_rem;

	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;
	wsg_pkg::item_t wr_item;
	wsg_pkg::item_t head;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q <= wsg_pkg::RST_WAVE_TYPE;
			amp_q       <= wsg_pkg::RST_AMPLITUDE;
			phase_q     <= wsg_pkg::RST_PHASE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wsg_pkg::REG_WAVE_TYPE: wave_type_q <= cfg_wdata[wsg_pkg::TYPE_W-1:0];
				wsg_pkg::REG_AMPLITUDE: amp_q       <= cfg_wdata[wsg_pkg::AMP_W-1:0];
				wsg_pkg::REG_PHASE:     phase_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// degree offset: divide half phase by 360, then fix the remainder
	assign deg_rem = 16'(phase_q[wsg_pkg::PHASE_W-1:1]) - 16'(int'(degq_q) * 360);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degq_q <= '0;
			deg_q  <= '0;
		end else begin
			degq_q <= wsg_pkg::degq_t'((int'(phase_q[wsg_pkg::PHASE_W-1:1]) * wsg_pkg::DEG_MUL)
				>> wsg_pkg::DEG_SHIFT);
			if (deg_rem >= 16'd360) begin
				deg_q <= wsg_pkg::deg_t'(deg_rem - 16'd360);
			end else begin
				deg_q <= wsg_pkg::deg_t'(deg_rem);
			end
		end
	end

	wsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.restart   (restart),
		.wave_type (wave_type_q),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.item      (wr_item)
	);

	wsg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	wsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.amplitude   (amp_q),
		.deg         (deg_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.sample      (sample),
		.point_index (point_index),
		.period_end  (period_end)
	);

endmodule
`default_nettype wire

>>> rtl/wsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_checker: port level checks of the waveform sample generator
// Watches the output channel for reset behavior, held words and a consistent
// period position, and the input channel for a held offer.
// ----------------------------------------------------------------------------
module wsg_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [wsg_pkg::SAMPLE_W-1:0]    sample,
	input wire logic [wsg_pkg::PIDX_W-1:0]      point_index,
	input wire logic                            period_end
);

	// no word leaves while reset is held
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word during reset");

	// hold a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample)
			&& $stable(point_index) && $stable(period_end))
		else $error("stalled output word changed");

	// period end only on the last point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_end |->
			point_index == wsg_pkg::pidx_t'(wsg_pkg::SAMPLES - 1))
		else $error("period end on wrong point");

	// point index stays inside the period
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wsg_pkg::SAMPLES > 512) || (point_index < wsg_pkg::SAMPLES))
		else $error("point index out of range");

	// an input word waiting on stall keeps offering
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input word withdrawn while stalled");

endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.sample      (sample),
	.point_index (point_index),
	.period_end  (period_end)
);
`default_nettype wire

>>> tb/sv/tb_waveform_sample_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_sample_generator: self-checking bench for the sample generator
// Streams restart words through the block under random gaps and output stalls.
// A scoreboard computes the expected sample, point index and period flag for
// each accepted word and compares them, in order, with the words that leave
// the block. It runs several register settings, extremes among them.
// ----------------------------------------------------------------------------
module tb_waveform_sample_generator;
	import wsg_pkg::*;

	// plain sine codes, any type above triangle
	localparam logic [TYPE_W-1:0] WAVE_PLAIN_LO = 3'd4;
	localparam logic [TYPE_W-1:0] WAVE_PLAIN_HI = 3'd7;

	// cycles to let the pipeline empty before a register write and at the end
	localparam int SETTLE_CYCLES = 24;
	localparam int GAP_PCT       = 29;

	// expected sample stream with its own copy of the registers and counter
	class wave_scoreboard;
		typedef struct {
			logic [SAMPLE_W-1:0] smp;
			logic [PIDX_W-1:0]   idx;
			logic                last;
		} point_t;

		localparam longint unsigned ONE_Q30 = 64'd1 << 30;
		localparam longint unsigned SIN_K1  = 64'd1686629713;
		localparam longint unsigned SIN_K3  = 64'd693598668;
		localparam longint unsigned SIN_K5  = 64'd85569305;
		localparam longint unsigned SIN_K7  = 64'd5026995;
		localparam longint unsigned SIN_K9  = 64'd172272;

		logic [TYPE_W-1:0]  wave_type;
		logic [AMP_W-1:0]   amplitude;
		logic [PHASE_W-1:0] phase_word;
		int unsigned        position;
		point_t             expected_q[$];
		int                 mismatches;

		function new();
			wave_type  = RST_WAVE_TYPE;
			amplitude  = RST_AMPLITUDE;
			phase_word = RST_PHASE;
			position   = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				REG_WAVE_TYPE: wave_type  = data[TYPE_W-1:0];
				REG_AMPLITUDE: amplitude  = data[AMP_W-1:0];
				REG_PHASE:     phase_word = data[PHASE_W-1:0];
				default: ;
			endcase
		endfunction

		// (sin + 1) in unsigned Q1.16 for an angle of num / (360 * SAMPLES) turns
		function longint unsigned sine_level(longint unsigned num);
			longint unsigned den, t, x, x2, p, s, s16, v, quad;
			den = 360 * SAMPLES;
			t = ((num % den) << 32) / den;
			quad = (t >> 30) & 3;
			x = t & (ONE_Q30 - 1);
			if (quad[0])
				x = ONE_Q30 - x;
			x2 = (x * x) >> 30;
			p = SIN_K9;
			p = SIN_K7 - ((x2 * p) >> 30);
			p = SIN_K5 - ((x2 * p) >> 30);
			p = SIN_K3 - ((x2 * p) >> 30);
			p = SIN_K1 - ((x2 * p) >> 30);
			s = (x * p) >> 30;
			if (s > ONE_Q30)
				s = ONE_Q30;
			s16 = (s + 8192) >> 14;
			if (s16 > 65536)
				s16 = 65536;
			v = (quad < 2) ? 65536 + s16 : 65536 - s16;
			if (v > 131071)
				v = 131071;
			return v;
		endfunction

		function logic [SAMPLE_W-1:0] level_at(longint unsigned i);
			longint unsigned a, n, r, d;
			a = amplitude;
			n = SAMPLES;
			case (wave_type)
				WAVE_SINE: begin
					d = (phase_word >> 1) % 360;
					r = (sine_level(i * 360 + d * n) * a + 65536) >> 17;
				end
				WAVE_SQUARE: r = (i < n / 2) ? a : 0;
				WAVE_SAW:    r = (i * a) / n;
				WAVE_TRI: begin
					if (i < n / 2)
						r = (2 * a * i) / n;
					else
						r = (2 * a * (n - i)) / n;
				end
				default: r = (sine_level(i * 360) * a) >> 17;
			endcase
			if (r > 255)
				r = 255;
			return r[SAMPLE_W-1:0];
		endfunction

		// note one accepted input word: advance the counter, queue the point
		function void note_word(logic restart_bit);
			point_t pt;
			int unsigned i;
			if (restart_bit)
				position = 0;
			if (position >= SAMPLES)
				position = 0;
			i = position;
			pt.smp  = level_at(i);
			pt.idx  = i[PIDX_W-1:0];
			pt.last = (i == SAMPLES - 1);
			expected_q.push_back(pt);
			position = (i + 1 >= SAMPLES) ? 0 : i + 1;
		endfunction

		// compare one output word with the oldest expected point
		function void check_word(logic [SAMPLE_W-1:0] smp, logic [PIDX_W-1:0] idx,
				logic last);
			point_t pt;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word sample=%0d index=%0d end=%0b",
						$time, smp, idx, last);
				return;
			end
			pt = expected_q.pop_front();
			if (smp !== pt.smp || idx !== pt.idx || last !== pt.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp sample/index/end %0d/%0d/%0b got %0d/%0d/%0b",
						$time, pt.smp, pt.idx, pt.last, smp, idx, last);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                restart;
	logic                out_valid;
	logic                out_stall;
	logic [SAMPLE_W-1:0] sample;
	logic [PIDX_W-1:0]   point_index;
	logic                period_end;
	logic                cfg_wr_en;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CDATA_W-1:0]  cfg_wdata;

	wave_scoreboard sb = new();
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int hold_cycles = 0;

	waveform_sample_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.point_index(point_index),
		.period_end(period_end),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// offer one word, hold it until taken, then note it
	task automatic send_word(logic r);
		while (tx_gaps && $urandom_range(99) < GAP_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= r;
		do @(posedge clk); while (in_stall);
		sb.note_word(r);
	endtask

	// drop valid, wait for every expected word, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers back to back; junk in unused data bits
	task automatic program_regs(logic [TYPE_W-1:0] wt, logic [AMP_W-1:0] amp,
			logic [PHASE_W-1:0] ph);
		logic [CDATA_W-1:0] d_type, d_amp;
		d_type = CDATA_W'($urandom_range(16'hFFFF));
		d_type[TYPE_W-1:0] = wt;
		d_amp  = {8'($urandom_range(255)), amp};
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_WAVE_TYPE;
		cfg_wdata <= d_type;
		sb.write_reg(REG_WAVE_TYPE, d_type);
		@(posedge clk);
		cfg_index <= REG_AMPLITUDE;
		cfg_wdata <= d_amp;
		sb.write_reg(REG_AMPLITUDE, d_amp);
		@(posedge clk);
		cfg_index <= REG_PHASE;
		cfg_wdata <= ph;
		sb.write_reg(REG_PHASE, ph);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		// phase passes phase_q and degq_q before it reaches the degree offset
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [TYPE_W-1:0] wt, logic [AMP_W-1:0] amp,
			logic [PHASE_W-1:0] ph, int count, int restart_pct);
		program_regs(wt, amp, ph);
		repeat (count)
			send_word($urandom_range(99) < restart_pct);
		settle();
	endtask

	// receive side: check taken words, stall at random or for a long hold
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_word(sample, point_index, period_end);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (rx_gaps) begin
				out_stall <= ($urandom_range(99) < GAP_PCT);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus
	initial begin
		logic [19:0] restart_seq;
		restart_seq = 20'b0110_0000_1100_1000_0001;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_WAVE_TYPE;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, with restarts back to back and isolated
		for (int k = 0; k < 20; k++)
			send_word(restart_seq[k]);
		settle();

		// extremes of every register and every wave type
		run_phase(WAVE_SINE, 8'd255, 16'hFFFF, 60, 0);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_phase(WAVE_TRI, 8'd255, 16'h0000, 60, 0);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_cycles = 200;
		run_phase(WAVE_SAW, 8'd255, 16'h0001, 60, 0);
		run_phase(WAVE_PLAIN_HI, 8'd255, 16'h0000, 60, 0);
		run_phase(WAVE_SINE, 8'd0, 16'd719, 60, 5);
		run_phase(WAVE_SINE, 8'd1, 16'd720, 60, 0);
		run_phase(WAVE_PLAIN_LO, 8'd128, 16'h5555, 60, 0);
		run_phase(WAVE_PLAIN_LO + 3'd1, 8'd200, 16'hAAAA, 60, 0);
		run_phase(WAVE_PLAIN_HI - 3'd1, 8'd255, 16'd359, 60, 0);
		run_phase(WAVE_SQUARE, 8'd0, 16'd1, 60, 5);

		// random settings
		repeat (4)
			run_phase(TYPE_W'($urandom_range(7)), AMP_W'($urandom_range(255)),
				PHASE_W'($urandom_range(16'hFFFF)), 45, int'($urandom_range(2)));

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
